// ===== rtl/core/adts_ff_pkg.sv =====
// adts_ff_pkg: shared types, constants and the rate table of the ADTS frame finder.
// No dependencies; used by adts_ff_frame_if and every module in rtl/core.
package adts_ff_pkg;

	localparam int POSITION_WIDTH_DEF    = 32;
	localparam int SAMPLES_PER_FRAME_DEF = 1024;
	localparam int QUEUE_DEPTH_DEF       = 4;

	localparam int OFFSET_W = 32;
	localparam int FLEN_W   = 13;
	localparam int IDX_W    = 4;
	localparam int RATE_W   = 17;
	localparam int TIME_W   = 64;
	localparam int INC_W    = 32;

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_GATHER = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	localparam logic [7:0]        SYNC_BYTE    = 8'hFF;
	localparam logic [3:0]        SYNC_NIBBLE  = 4'hF;
	localparam logic [2:0]        HDR_LAST     = 3'd6;
	localparam logic [FLEN_W-1:0] HDR_LEN      = 13'd7;
	localparam logic [IDX_W-1:0]  IDX_LAST_VALID = 4'd12;

	typedef struct packed {
		logic                clear;
		logic [OFFSET_W-1:0] offset;
		logic [FLEN_W-1:0]   flen;
		logic                crc;
		logic [IDX_W-1:0]    idx;
	} hdr_rec_t;

	function automatic logic [RATE_W-1:0] rate_of(input logic [IDX_W-1:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd0:    r = 17'd96000;
			4'd1:    r = 17'd88200;
			4'd2:    r = 17'd64000;
			4'd3:    r = 17'd48000;
			4'd4:    r = 17'd44100;
			4'd5:    r = 17'd32000;
			4'd6:    r = 17'd24000;
			4'd7:    r = 17'd22050;
			4'd8:    r = 17'd16000;
			4'd9:    r = 17'd12000;
			4'd10:   r = 17'd11025;
			4'd11:   r = 17'd8000;
			4'd12:   r = 17'd7350;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/adts_ff_byte_if.sv =====
// adts_ff_byte_if: valid/ready channel carrying one stream byte per item.
// Depends on nothing.
interface adts_ff_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, data_byte, restart, input ready);
	modport sink   (input valid, data_byte, restart, output ready);
endinterface

// ===== rtl/core/adts_ff_frame_if.sv =====
// adts_ff_frame_if: valid/ready channel carrying one decoded ADTS header per item.
// Depends on adts_ff_pkg for field widths.
interface adts_ff_frame_if;
	logic                             valid;
	logic                             ready;
	logic [adts_ff_pkg::OFFSET_W-1:0] frame_offset;
	logic [adts_ff_pkg::FLEN_W-1:0]   frame_length;
	logic                             crc_present;
	logic [adts_ff_pkg::IDX_W-1:0]    rate_index;
	logic [adts_ff_pkg::RATE_W-1:0]   rate_hz;
	logic                             rate_valid;
	logic [adts_ff_pkg::TIME_W-1:0]   timestamp_us;

	modport source (output valid, frame_offset, frame_length, crc_present, rate_index,
		rate_hz, rate_valid, timestamp_us, input ready);
	modport sink   (input valid, frame_offset, frame_length, crc_present, rate_index,
		rate_hz, rate_valid, timestamp_us, output ready);
endinterface

// ===== rtl/core/adts_ff_front.sv =====
// adts_ff_front: sync hunt, header capture and frame skip, one byte per cycle while the queue is not full.
// Depends on adts_ff_pkg and adts_ff_byte_if; pushes header records into the queue.
module adts_ff_front #(
	parameter int POSITION_WIDTH = adts_ff_pkg::POSITION_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	adts_ff_byte_if.sink          bytes,
	output logic                  q_push,
	output adts_ff_pkg::hdr_rec_t q_rec,
	input  logic                  q_full
);

	logic [1:0]                       phase_q, phase_n, eff_phase;
	logic [2:0]                       cnt_q, cnt_n, eff_cnt;
	logic [adts_ff_pkg::FLEN_W-1:0]   skip_q, skip_n, eff_skip, flen;
	logic [POSITION_WIDTH-1:0]        pos_q, eff_pos, sync_q, sync_n;
	logic                             pend_q;
	logic                             crc_q, crc_n;
	logic [adts_ff_pkg::IDX_W-1:0]    idx_q, idx_n;
	logic [1:0]                       fhi_q, fhi_n;
	logic [7:0]                       fmid_q, fmid_n;
	logic [2:0]                       flo_q, flo_n;
	logic                             accept, emit;
	logic [7:0]                       b;

	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.data_byte;

	assign eff_phase = bytes.restart ? adts_ff_pkg::PH_HUNT : phase_q;
	assign eff_cnt   = bytes.restart ? 3'd0 : cnt_q;
	assign eff_skip  = bytes.restart ? '0 : skip_q;
	assign eff_pos   = bytes.restart ? '0 : pos_q;
	assign flen      = {fhi_q, fmid_q, flo_q};

	always_comb begin
		phase_n = eff_phase;
		cnt_n   = eff_cnt;
		skip_n  = eff_skip;
		sync_n  = sync_q;
		crc_n   = crc_q;
		idx_n   = idx_q;
		fhi_n   = fhi_q;
		fmid_n  = fmid_q;
		flo_n   = flo_q;
		emit    = 1'b0;
		case (eff_phase)
			adts_ff_pkg::PH_GATHER: begin
				if (eff_cnt == 3'd1) begin
					if (b[7:4] == adts_ff_pkg::SYNC_NIBBLE) begin
						crc_n = !b[0];
						cnt_n = 3'd2;
					end else if (b == adts_ff_pkg::SYNC_BYTE) begin
						cnt_n  = 3'd1;
						sync_n = eff_pos;
					end else begin
						phase_n = adts_ff_pkg::PH_HUNT;
						cnt_n   = 3'd0;
					end
				end else if (eff_cnt >= 3'd2 && eff_cnt <= adts_ff_pkg::HDR_LAST) begin
					cnt_n = eff_cnt + 3'd1;
					case (eff_cnt)
						3'd2:    idx_n  = b[5:2];
						3'd3:    fhi_n  = b[1:0];
						3'd4:    fmid_n = b;
						3'd5:    flo_n  = b[7:5];
						default: begin
							emit  = 1'b1;
							cnt_n = 3'd0;
							if (flen > adts_ff_pkg::HDR_LEN) begin
								skip_n  = flen - adts_ff_pkg::HDR_LEN;
								phase_n = adts_ff_pkg::PH_SKIP;
							end else begin
								skip_n  = '0;
								phase_n = adts_ff_pkg::PH_HUNT;
							end
						end
					endcase
				end else begin
					phase_n = adts_ff_pkg::PH_HUNT;
					cnt_n   = 3'd0;
				end
			end
			adts_ff_pkg::PH_SKIP: begin
				if (eff_skip != '0)
					skip_n = eff_skip - 13'd1;
				if (skip_n == '0)
					phase_n = adts_ff_pkg::PH_HUNT;
			end
			default: begin
				if (b == adts_ff_pkg::SYNC_BYTE) begin
					phase_n = adts_ff_pkg::PH_GATHER;
					cnt_n   = 3'd1;
					sync_n  = eff_pos;
				end else begin
					phase_n = adts_ff_pkg::PH_HUNT;
				end
			end
		endcase
	end

	assign q_push       = accept && emit;
	assign q_rec.clear  = pend_q;
	assign q_rec.offset = adts_ff_pkg::OFFSET_W'(sync_q);
	assign q_rec.flen   = flen;
	assign q_rec.crc    = crc_q;
	assign q_rec.idx    = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adts_ff_pkg::PH_HUNT;
			cnt_q   <= 3'd0;
			skip_q  <= '0;
			pos_q   <= '0;
			sync_q  <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			skip_q  <= skip_n;
			pos_q   <= eff_pos + POSITION_WIDTH'(1);
			sync_q  <= sync_n;
			if (bytes.restart)
				pend_q <= 1'b1;
			else if (emit)
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			crc_q  <= crc_n;
			idx_q  <= idx_n;
			fhi_q  <= fhi_n;
			fmid_q <= fmid_n;
			flo_q  <= flo_n;
		end
	end

`ifndef SYNTH
	a_push_from_last_hdr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!bytes.restart && phase_q == adts_ff_pkg::PH_GATHER
			&& cnt_q == adts_ff_pkg::HDR_LAST))
		else $error("header pushed outside last header byte");
	a_cnt_only_gathering: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != adts_ff_pkg::PH_GATHER) |-> (cnt_q == 3'd0))
		else $error("header count nonzero outside gathering");
	a_gather_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == adts_ff_pkg::PH_GATHER) |->
			(cnt_q != 3'd0 && cnt_q <= adts_ff_pkg::HDR_LAST))
		else $error("header count out of range while gathering");
`endif

endmodule

// ===== rtl/core/adts_ff_queue.sv =====
// adts_ff_queue: small register queue of header records between front and back.
// Depends on adts_ff_pkg for the record type.
module adts_ff_queue #(
	parameter int DEPTH = adts_ff_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  adts_ff_pkg::hdr_rec_t wr_rec,
	output logic                  full,
	input  logic                  pop,
	output adts_ff_pkg::hdr_rec_t rd_rec,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	adts_ff_pkg::hdr_rec_t slot_q [DEPTH];
	logic [PTR_W-1:0]      wp_q, rp_q;
	logic [CNT_W-1:0]      count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_rec = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			if (pop)
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= wr_rec;
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty) && count_q <= CNT_W'(DEPTH))
		else $error("queue overflow or underflow");
`endif

endmodule

// ===== rtl/core/adts_ff_back.sv =====
// adts_ff_back: rate lookup, timestamp accumulation and the output register.
// Depends on adts_ff_pkg and adts_ff_frame_if; drains header records from the queue.
module adts_ff_back #(
	parameter int SAMPLES_PER_FRAME = adts_ff_pkg::SAMPLES_PER_FRAME_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  adts_ff_pkg::hdr_rec_t q_rec,
	output logic                  q_pop,
	adts_ff_frame_if.source       frames
);

	localparam longint unsigned USF = 64'd1000000 * 64'(SAMPLES_PER_FRAME);
	localparam logic [adts_ff_pkg::INC_W-1:0] INC [13] = '{
		32'(USF / 96000), 32'(USF / 88200), 32'(USF / 64000), 32'(USF / 48000),
		32'(USF / 44100), 32'(USF / 32000), 32'(USF / 24000), 32'(USF / 22050),
		32'(USF / 16000), 32'(USF / 12000), 32'(USF / 11025), 32'(USF / 8000),
		32'(USF / 7350)
	};

	logic [adts_ff_pkg::TIME_W-1:0] time_q, time_base, time_n;
	logic [adts_ff_pkg::INC_W-1:0]  inc;
	logic                           valid_idx;
	logic                           vld_q;

	assign valid_idx = (q_rec.idx <= adts_ff_pkg::IDX_LAST_VALID);
	assign inc       = valid_idx ? INC[q_rec.idx] : '0;
	assign time_base = q_rec.clear ? '0 : time_q;
	assign time_n    = time_base + adts_ff_pkg::TIME_W'(inc);

	assign q_pop        = !q_empty && (!vld_q || frames.ready);
	assign frames.valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			time_q <= '0;
		end else begin
			if (q_pop) begin
				vld_q  <= 1'b1;
				time_q <= time_n;
			end else if (frames.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frames.frame_offset <= q_rec.offset;
			frames.frame_length <= q_rec.flen;
			frames.crc_present  <= q_rec.crc;
			frames.rate_index   <= q_rec.idx;
			frames.rate_hz      <= adts_ff_pkg::rate_of(q_rec.idx);
			frames.rate_valid   <= valid_idx;
			frames.timestamp_us <= time_n;
		end
	end

`ifndef SYNTH
	a_pop_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (vld_q && frames.timestamp_us == time_q))
		else $error("popped record did not reach the output register");
`endif

endmodule

// ===== rtl/core/adts_frame_finder.sv =====
// adts_frame_finder: ADTS header finder, one stream byte accepted per cycle unless the queue is full.
// The seventh header byte's record goes through the header queue into the output register.
// Throughput is one byte per cycle; input stalls only when the header queue is full.
// arst_n clears hunt state, counters, position, timestamp, queue and output valid.
// No clearing pass: the block is ready for bytes as soon as reset is released.
module adts_frame_finder #(
	parameter int POSITION_WIDTH    = adts_ff_pkg::POSITION_WIDTH_DEF,
	parameter int SAMPLES_PER_FRAME = adts_ff_pkg::SAMPLES_PER_FRAME_DEF,
	parameter int QUEUE_DEPTH       = adts_ff_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	adts_ff_byte_if.sink    bytes,
	adts_ff_frame_if.source frames
);

	logic                  q_push, q_pop, q_full, q_empty;
	adts_ff_pkg::hdr_rec_t wr_rec, rd_rec;

	adts_ff_front #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.q_push (q_push),
		.q_rec  (wr_rec),
		.q_full (q_full)
	);

	adts_ff_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_rec (wr_rec),
		.full   (q_full),
		.pop    (q_pop),
		.rd_rec (rd_rec),
		.empty  (q_empty)
	);

	adts_ff_back #(
		.SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rec   (rd_rec),
		.q_pop   (q_pop),
		.frames  (frames)
	);

endmodule
